### rtl/core/jgc_pkg.sv
// Package: payload words, codes and arithmetic helpers for the joystick gesture conditioner.
`default_nettype none

package jgc_pkg;

  // Axis calibration points
  localparam int unsigned X_REST = 2203;
  localparam int unsigned X_MAX  = 3835;
  localparam int unsigned X_MIN  = 454;
  localparam int unsigned Y_REST = 2233;
  localparam int unsigned Y_MAX  = 3900;
  localparam int unsigned Y_MIN  = 343;

  // Percent scaling: floor(100*d/D) = (d * 100 * ceil(2^SHIFT/D)) >> SHIFT, exact for d < D
  localparam int unsigned PCT_SHIFT = 29;
  localparam int unsigned PCT_MUL_W = 25;
  localparam int unsigned PCT_PROD_W = 11 + PCT_MUL_W;

  localparam int unsigned X_POS_DIV = X_MAX - X_REST;
  localparam int unsigned X_NEG_DIV = X_REST - X_MIN;
  localparam int unsigned Y_POS_DIV = Y_MAX - Y_REST;
  localparam int unsigned Y_NEG_DIV = Y_REST - Y_MIN;

  localparam longint unsigned X_POS_MUL =
    64'd100 * (((64'd1 << PCT_SHIFT) + X_POS_DIV - 1) / X_POS_DIV);
  localparam longint unsigned X_NEG_MUL =
    64'd100 * (((64'd1 << PCT_SHIFT) + X_NEG_DIV - 1) / X_NEG_DIV);
  localparam longint unsigned Y_POS_MUL =
    64'd100 * (((64'd1 << PCT_SHIFT) + Y_POS_DIV - 1) / Y_POS_DIV);
  localparam longint unsigned Y_NEG_MUL =
    64'd100 * (((64'd1 << PCT_SHIFT) + Y_NEG_DIV - 1) / Y_NEG_DIV);

  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [9:0]  MAX_INC     = 10'd550;
  localparam logic [23:0] GOAL_MARGIN = 24'd10;
  localparam logic [15:0] PRESS_SAT   = 16'hFFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_X_LEFT       = 3'd0;
  localparam logic [2:0] REG_X_RIGHT      = 3'd1;
  localparam logic [2:0] REG_Y_DOWN       = 3'd2;
  localparam logic [2:0] REG_Y_UP         = 3'd3;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd4;
  localparam logic [2:0] REG_INITIAL_GOAL = 3'd5;

  localparam logic [11:0] X_LEFT_RESET     = 12'd2864;
  localparam logic [11:0] X_RIGHT_RESET    = 12'd1542;
  localparam logic [11:0] Y_DOWN_RESET     = 12'd2679;
  localparam logic [11:0] Y_UP_RESET       = 12'd1786;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd56;
  localparam logic [23:0] GOAL_RESET       = 24'd1000;

  typedef enum logic [1:0] {
    DIR_REST       = 2'd0,
    DIR_LEFT_UP    = 2'd1,
    DIR_RIGHT_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MODE_STEPS    = 2'd0,
    MODE_GOAL     = 2'd1,
    MODE_DISTANCE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic        button;
    logic        test_mode;
    logic [23:0] current_steps;
    logic [23:0] proposed_goal;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  x_percent;
    logic [6:0]  y_percent;
    logic [1:0]  x_direction;
    logic [1:0]  y_direction;
    logic [1:0]  display_mode;
    logic        distance_units;
    logic        step_units;
    logic        setting_goal;
    logic [23:0] goal_out;
    logic [23:0] steps_out;
  } out_word_t;

  // One side of an axis: clamp at full scale, else scale by the reciprocal constant
  function automatic logic [6:0] side_percent(input logic [11:0] d,
                                              input logic [11:0] div,
                                              input logic [PCT_MUL_W-1:0] mul);
    logic [PCT_PROD_W-1:0] prod;
    prod = PCT_PROD_W'(d[10:0]) * PCT_PROD_W'(mul);
    if (d >= div) begin
      side_percent = PCT_FULL;
    end else begin
      side_percent = prod[PCT_SHIFT +: 7];
    end
  endfunction

  // Test-mode step increment, nonlinear in the Y percent
  function automatic logic [9:0] step_increment(input logic [6:0] p);
    logic [4:0] k;
    logic [7:0] ramp;
    k = 5'(p - 7'd71);
    case (k)
      5'd0:    ramp = 8'd0;
      5'd1:    ramp = 8'd9;
      5'd2:    ramp = 8'd18;
      5'd3:    ramp = 8'd28;
      5'd4:    ramp = 8'd37;
      5'd5:    ramp = 8'd46;
      5'd6:    ramp = 8'd56;
      5'd7:    ramp = 8'd65;
      5'd8:    ramp = 8'd75;
      5'd9:    ramp = 8'd84;
      5'd10:   ramp = 8'd93;
      5'd11:   ramp = 8'd103;
      5'd12:   ramp = 8'd112;
      5'd13:   ramp = 8'd121;
      5'd14:   ramp = 8'd131;
      5'd15:   ramp = 8'd140;
      5'd16:   ramp = 8'd150;
      5'd17:   ramp = 8'd159;
      5'd18:   ramp = 8'd168;
      5'd19:   ramp = 8'd178;
      5'd20:   ramp = 8'd187;
      5'd21:   ramp = 8'd196;
      5'd22:   ramp = 8'd206;
      5'd23:   ramp = 8'd215;
      default: ramp = 8'd0;
    endcase
    if (p < 7'd4) begin
      step_increment = 10'd0;
    end else if (p < 7'd35) begin
      step_increment = 10'd1;
    end else if (p < 7'd45) begin
      step_increment = 10'd2;
    end else if (p < 7'd55) begin
      step_increment = 10'd5;
    end else if (p < 7'd63) begin
      step_increment = 10'd10;
    end else if (p < 7'd71) begin
      step_increment = 10'd15;
    end else if (p < 7'd95) begin
      step_increment = 10'd25 + 10'(ramp);
    end else begin
      step_increment = MAX_INC;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/joystick_gesture_conditioner.sv
// Top level: joystick sample scaling, direction classes, gesture state and step nudging.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------
//   input   | in_valid  | in_stall  | in_data  (in_word_t)
//   output  | out_valid | out_stall | out_data (out_word_t)
//   config  | cfg_en    | -         | cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; an accepted word passes the
// input register, then one pass of scaling, compare and flag logic into the result register.
// Gesture state updates in the same cycle a word moves into the result register.
// Reset is synchronous on rst and reloads thresholds, goal and gesture state.
// A stalled result holds; the input register keeps accepting until it too is full.
`default_nettype none

module joystick_gesture_conditioner
  import jgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data
);

  // Configuration
  logic [11:0] x_left_threshold;
  logic [11:0] x_right_threshold;
  logic [11:0] y_down_threshold;
  logic [11:0] y_up_threshold;
  logic [15:0] press_limit;

  // Gesture state
  logic [1:0]  last_x_direction, last_x_direction_next;
  logic [1:0]  last_y_direction, last_y_direction_next;
  logic [1:0]  display_mode, display_mode_next;
  logic        distance_unit, distance_unit_next;
  logic        step_unit, step_unit_next;
  logic        goal_mode, goal_mode_next;
  logic [15:0] press_counter, press_counter_next;
  logic        press_handled, press_handled_next;
  logic [23:0] goal, goal_next;

  // Pipeline
  logic      hold_valid;
  in_word_t  hold;
  logic      advance;
  out_word_t result_next;

  // Datapath temporaries
  logic [11:0] x_d, y_d;
  logic [6:0]  x_pct, y_pct;
  logic [1:0]  x_dir, y_dir, y_dir_out;
  logic [15:0] press_inc;
  logic [9:0]  inc;
  logic [23:0] cap, steps_dec, steps_adj;
  logic [24:0] steps_sum;

  assign advance  = hold_valid && !(out_valid && out_stall);
  assign in_stall = hold_valid && !advance;

  // The initial goal only takes effect at reset, where it is reloaded with its default,
  // so a write to it leaves nothing to hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_left_threshold  <= X_LEFT_RESET;
      x_right_threshold <= X_RIGHT_RESET;
      y_down_threshold  <= Y_DOWN_RESET;
      y_up_threshold    <= Y_UP_RESET;
      press_limit       <= LONG_PRESS_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_X_LEFT:       x_left_threshold  <= cfg_data[11:0];
        REG_X_RIGHT:      x_right_threshold <= cfg_data[11:0];
        REG_Y_DOWN:       y_down_threshold  <= cfg_data[11:0];
        REG_Y_UP:         y_up_threshold    <= cfg_data[11:0];
        REG_LONG_PRESS:   press_limit       <= cfg_data[15:0];
        REG_INITIAL_GOAL: ;
        default:          ;
      endcase
    end
  end

  always_comb begin
    // Percent displacement per axis, separate scale on each side of rest
    if (hold.raw_x > 12'(X_REST)) begin
      x_d   = hold.raw_x - 12'(X_REST);
      x_pct = side_percent(x_d, 12'(X_POS_DIV), PCT_MUL_W'(X_POS_MUL));
    end else begin
      x_d   = 12'(X_REST) - hold.raw_x;
      x_pct = side_percent(x_d, 12'(X_NEG_DIV), PCT_MUL_W'(X_NEG_MUL));
    end
    if (hold.raw_y > 12'(Y_REST)) begin
      y_d   = hold.raw_y - 12'(Y_REST);
      y_pct = side_percent(y_d, 12'(Y_POS_DIV), PCT_MUL_W'(Y_POS_MUL));
    end else begin
      y_d   = 12'(Y_REST) - hold.raw_y;
      y_pct = side_percent(y_d, 12'(Y_NEG_DIV), PCT_MUL_W'(Y_NEG_MUL));
    end

    if (hold.raw_x > x_left_threshold) begin
      x_dir = DIR_LEFT_UP;
    end else if (hold.raw_x < x_right_threshold) begin
      x_dir = DIR_RIGHT_DOWN;
    end else begin
      x_dir = DIR_REST;
    end
    if (hold.raw_y < y_up_threshold) begin
      y_dir = DIR_LEFT_UP;
    end else if (hold.raw_y > y_down_threshold) begin
      y_dir = DIR_RIGHT_DOWN;
    end else begin
      y_dir = DIR_REST;
    end

    last_x_direction_next = last_x_direction;
    last_y_direction_next = last_y_direction;
    display_mode_next     = display_mode;
    distance_unit_next    = distance_unit;
    step_unit_next        = step_unit;
    goal_mode_next        = goal_mode;
    press_counter_next    = press_counter;
    press_handled_next    = press_handled;
    goal_next             = goal;
    y_dir_out             = y_dir;

    // Unit toggle on an up edge from rest; down reads as rest here
    if (!goal_mode && !hold.test_mode) begin
      if (y_dir == DIR_LEFT_UP) begin
        if (last_y_direction == DIR_REST) begin
          if (display_mode == MODE_DISTANCE) begin
            distance_unit_next = !distance_unit;
          end else begin
            step_unit_next = !step_unit;
          end
        end
      end else begin
        y_dir_out = DIR_REST;
      end
      last_y_direction_next = y_dir_out;
    end

    // Display cycle on a left or right edge from rest
    if (!goal_mode && hold.raw_x != 12'd0) begin
      if (last_x_direction == DIR_REST) begin
        if (x_dir == DIR_LEFT_UP) begin
          case (display_mode)
            MODE_STEPS:    display_mode_next = MODE_DISTANCE;
            MODE_GOAL:     display_mode_next = MODE_STEPS;
            MODE_DISTANCE: display_mode_next = MODE_GOAL;
            default:       display_mode_next = MODE_STEPS;
          endcase
        end else if (x_dir == DIR_RIGHT_DOWN) begin
          case (display_mode)
            MODE_STEPS:    display_mode_next = MODE_GOAL;
            MODE_GOAL:     display_mode_next = MODE_DISTANCE;
            MODE_DISTANCE: display_mode_next = MODE_STEPS;
            default:       display_mode_next = MODE_STEPS;
          endcase
        end
      end
      last_x_direction_next = x_dir;
    end

    // Goal progress mode: a long press enters or confirms goal setting, a short press cancels it
    press_inc = (press_counter < PRESS_SAT) ? press_counter + 16'd1 : press_counter;
    if (display_mode_next == MODE_GOAL) begin
      if (hold.button) begin
        press_counter_next = press_inc;
        if (press_inc >= press_limit && !press_handled) begin
          if (goal_mode) begin
            goal_next = hold.proposed_goal;
          end
          goal_mode_next     = !goal_mode;
          press_counter_next = 16'd0;
          press_handled_next = 1'b1;
        end
      end else begin
        if (press_counter != 16'd0 && goal_mode && !press_handled) begin
          goal_mode_next = 1'b0;
        end
        press_counter_next = 16'd0;
        press_handled_next = 1'b0;
      end
    end

    // Test-mode nudge: decrement floored at zero, then increment capped below the goal
    inc       = step_increment(y_pct);
    cap       = (goal_next >= GOAL_MARGIN) ? goal_next - GOAL_MARGIN : 24'd0;
    steps_dec = hold.current_steps;
    if (hold.raw_y > y_down_threshold) begin
      steps_dec = (hold.current_steps <= 24'(inc)) ? 24'd0 : hold.current_steps - 24'(inc);
    end
    steps_sum = 25'(steps_dec) + 25'(inc);
    steps_adj = steps_dec;
    if (hold.raw_y < y_up_threshold) begin
      steps_adj = (steps_sum <= 25'(cap)) ? steps_sum[23:0] : cap;
    end

    result_next.x_percent      = x_pct;
    result_next.y_percent      = y_pct;
    result_next.x_direction    = x_dir;
    result_next.y_direction    = y_dir_out;
    result_next.display_mode   = display_mode_next;
    result_next.distance_units = distance_unit_next;
    result_next.step_units     = step_unit_next;
    result_next.setting_goal   = goal_mode_next;
    result_next.goal_out       = goal_next;
    result_next.steps_out      = (hold.test_mode && !goal_mode_next) ? steps_adj
                                                                     : hold.current_steps;
  end

  // Input register: take a word whenever it is empty or draining this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold <= in_data;
    end
  end

  // Result register and gesture state advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      last_x_direction <= DIR_REST;
      last_y_direction <= DIR_REST;
      display_mode     <= MODE_STEPS;
      distance_unit    <= 1'b0;
      step_unit        <= 1'b0;
      goal_mode        <= 1'b0;
      press_counter    <= 16'd0;
      press_handled    <= 1'b0;
      goal             <= GOAL_RESET;
    end else begin
      if (advance) begin
        out_valid        <= 1'b1;
        last_x_direction <= last_x_direction_next;
        last_y_direction <= last_y_direction_next;
        display_mode     <= display_mode_next;
        distance_unit    <= distance_unit_next;
        step_unit        <= step_unit_next;
        goal_mode        <= goal_mode_next;
        press_counter    <= press_counter_next;
        press_handled    <= press_handled_next;
        goal             <= goal_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

endmodule

`default_nettype wire

### verif/joystick_gesture_conditioner_tb.sv
// Testbench for the joystick gesture conditioner: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module joystick_gesture_conditioner_tb;
  import jgc_pkg::*;

  localparam int unsigned STUCK_LIMIT = 2000;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_en    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;

  joystick_gesture_conditioner u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Register copies
  logic [11:0] x_left_thr, x_right_thr, y_down_thr, y_up_thr;
  logic [15:0] long_press_thr;
  logic [23:0] init_goal_cfg;

  // Gesture state copy
  dir_t        last_xd, last_yd;
  mode_t       disp_mode;
  logic        dist_units, step_units, goal_setting, press_done;
  logic [15:0] press_cnt;
  logic [23:0] goal;

  out_word_t   tick_results_q[$];
  out_word_t   want, predicted;

  int unsigned fail_count     = 0;
  int unsigned words_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used  = 0;
  int unsigned goal_toggles   = 0;
  int unsigned nudged_words   = 0;
  int unsigned stuck_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned axis_pct(input int unsigned v, input int unsigned rest,
                                           input int unsigned hi, input int unsigned lo);
    int unsigned p;
    if (v > rest) begin
      p = (v - rest) * 100 / (hi - rest);
    end else begin
      p = (rest - v) * 100 / (rest - lo);
    end
    return (p > 100) ? 100 : p;
  endfunction

  // Advance the gesture state by one word and build the word it should produce
  task automatic condition_tick(input in_word_t w, output out_word_t r);
    int unsigned xp, yp, inc, cap, steps;
    dir_t xd, yd;
    xp = axis_pct(w.raw_x, X_REST, X_MAX, X_MIN);
    yp = axis_pct(w.raw_y, Y_REST, Y_MAX, Y_MIN);
    if (w.raw_x > x_left_thr) xd = DIR_LEFT_UP;
    else if (w.raw_x < x_right_thr) xd = DIR_RIGHT_DOWN;
    else xd = DIR_REST;
    if (w.raw_y < y_up_thr) yd = DIR_LEFT_UP;
    else if (w.raw_y > y_down_thr) yd = DIR_RIGHT_DOWN;
    else yd = DIR_REST;

    if (!goal_setting && !w.test_mode) begin
      if (yd == DIR_LEFT_UP) begin
        if (last_yd == DIR_REST) begin
          if (disp_mode == MODE_DISTANCE) dist_units = ~dist_units;
          else step_units = ~step_units;
        end
      end else begin
        // down reads as rest outside test and goal setting
        yd = DIR_REST;
      end
      last_yd = yd;
    end

    if (!goal_setting && w.raw_x != 12'd0) begin
      if (last_xd == DIR_REST && xd != DIR_REST) begin
        case (disp_mode)
          MODE_STEPS: begin
            disp_mode = (xd == DIR_LEFT_UP) ? MODE_DISTANCE : MODE_GOAL;
          end
          MODE_GOAL: begin
            disp_mode = (xd == DIR_LEFT_UP) ? MODE_STEPS : MODE_DISTANCE;
          end
          default: begin
            disp_mode = (xd == DIR_LEFT_UP) ? MODE_GOAL : MODE_STEPS;
          end
        endcase
      end
      last_xd = xd;
    end

    if (disp_mode == MODE_GOAL) begin
      if (w.button) begin
        if (press_cnt != PRESS_SAT) press_cnt++;
        if (press_cnt >= long_press_thr && !press_done) begin
          if (goal_setting) goal = w.proposed_goal;
          goal_setting = ~goal_setting;
          press_cnt    = '0;
          press_done   = 1'b1;
          goal_toggles++;
        end
      end else begin
        // short press while setting cancels
        if (press_cnt != 16'd0 && goal_setting && !press_done) goal_setting = 1'b0;
        press_cnt  = '0;
        press_done = 1'b0;
      end
    end

    steps = w.current_steps;
    if (w.test_mode && !goal_setting) begin
      if (yp < 4) inc = 0;
      else if (yp < 35) inc = 1;
      else if (yp < 45) inc = 2;
      else if (yp < 55) inc = 5;
      else if (yp < 63) inc = 10;
      else if (yp < 71) inc = 15;
      else if (yp < 95) inc = 25 + (yp - 71) * 225 / 24;
      else inc = MAX_INC;
      cap = (goal >= GOAL_MARGIN) ? goal - GOAL_MARGIN : 0;
      // decrement first, then increment, when both thresholds fire
      if (w.raw_y > y_down_thr) steps = (steps <= inc) ? 0 : steps - inc;
      if (w.raw_y < y_up_thr) steps = (steps + inc <= cap) ? steps + inc : cap;
      nudged_words++;
    end

    r.x_percent      = 7'(xp);
    r.y_percent      = 7'(yp);
    r.x_direction    = xd;
    r.y_direction    = yd;
    r.display_mode   = disp_mode;
    r.distance_units = dist_units;
    r.step_units     = step_units;
    r.setting_goal   = goal_setting;
    r.goal_out       = goal;
    r.steps_out      = 24'(steps);
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Predict on accepted input words, check accepted result words, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      x_left_thr     = X_LEFT_RESET;
      x_right_thr    = X_RIGHT_RESET;
      y_down_thr     = Y_DOWN_RESET;
      y_up_thr       = Y_UP_RESET;
      long_press_thr = LONG_PRESS_RESET;
      init_goal_cfg  = GOAL_RESET;
      last_xd        = DIR_REST;
      last_yd        = DIR_REST;
      disp_mode      = MODE_STEPS;
      dist_units     = 1'b0;
      step_units     = 1'b0;
      goal_setting   = 1'b0;
      press_done     = 1'b0;
      press_cnt      = '0;
      goal           = init_goal_cfg;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_X_LEFT:       x_left_thr     = cfg_data[11:0];
          REG_X_RIGHT:      x_right_thr    = cfg_data[11:0];
          REG_Y_DOWN:       y_down_thr     = cfg_data[11:0];
          REG_Y_UP:         y_up_thr       = cfg_data[11:0];
          REG_LONG_PRESS:   long_press_thr = cfg_data[15:0];
          REG_INITIAL_GOAL: init_goal_cfg  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (tick_results_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("x_percent", 24'(want.x_percent), 24'(out_data.x_percent));
          check_field("y_percent", 24'(want.y_percent), 24'(out_data.y_percent));
          check_field("x_direction", 24'(want.x_direction), 24'(out_data.x_direction));
          check_field("y_direction", 24'(want.y_direction), 24'(out_data.y_direction));
          check_field("display_mode", 24'(want.display_mode), 24'(out_data.display_mode));
          check_field("distance_units", 24'(want.distance_units),
                      24'(out_data.distance_units));
          check_field("step_units", 24'(want.step_units), 24'(out_data.step_units));
          check_field("setting_goal", 24'(want.setting_goal), 24'(out_data.setting_goal));
          check_field("goal_out", want.goal_out, out_data.goal_out);
          check_field("steps_out", want.steps_out, out_data.steps_out);
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        condition_tick(in_data, predicted);
        tick_results_q.push_back(predicted);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: clear runs, choppy runs and the odd long hold
  initial begin : out_stall_pattern
    int unsigned seg, n;
    forever begin
      seg = $urandom_range(0, 9);
      n   = $urandom_range(5, 60);
      if (seg < 3) begin
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b0;
        end
      end else if (seg < 9) begin
        repeat (n) begin
          @(negedge clk);
          out_stall <= ($urandom_range(0, 2) == 0);
        end
      end else begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 40)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the word is taken
  task automatic send_word(input in_word_t w, input bit tight);
    int unsigned gap, r;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
    r = $urandom_range(0, 99);
    if (tight || r < 65) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and hold until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic write_settings(input logic [11:0] xl, input logic [11:0] xr,
                                input logic [11:0] yd, input logic [11:0] yu,
                                input logic [15:0] lp, input logic [23:0] ig);
    wait_idle();
    write_reg(REG_X_LEFT, 24'(xl));
    write_reg(REG_X_RIGHT, 24'(xr));
    write_reg(REG_Y_DOWN, 24'(yd));
    write_reg(REG_Y_UP, 24'(yu));
    write_reg(REG_LONG_PRESS, 24'(lp));
    write_reg(REG_INITIAL_GOAL, ig);
    cfg_en <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  function automatic in_word_t make_word(input logic [11:0] x, input logic [11:0] y,
                                         input logic btn, input logic test,
                                         input logic [23:0] steps, input logic [23:0] prop);
    in_word_t w;
    w.raw_x         = x;
    w.raw_y         = y;
    w.button        = btn;
    w.test_mode     = test;
    w.current_steps = steps;
    w.proposed_goal = prop;
    return w;
  endfunction

  // Class 0: between thresholds, 1: above hi_thr, 2: below lo_thr (never 0 unless forced),
  // anything else or an empty class: whole range. Endpoints come up often.
  function automatic logic [11:0] axis_sample(input int unsigned cls, input int unsigned lo_thr,
                                              input int unsigned hi_thr);
    int unsigned lo_v, hi_v, r;
    lo_v = 0;
    hi_v = 4095;
    case (cls)
      0: if (lo_thr <= hi_thr) begin
        lo_v = lo_thr;
        hi_v = hi_thr;
      end
      1: if (hi_thr < 4095) begin
        lo_v = hi_thr + 1;
      end
      2: if (lo_thr >= 2) begin
        lo_v = 1;
        hi_v = lo_thr - 1;
      end else if (lo_thr == 1) begin
        hi_v = 0;
      end
      default: ;
    endcase
    r = $urandom_range(0, 3);
    if (r == 0) return 12'(lo_v);
    if (r == 1) return 12'(hi_v);
    return 12'($urandom_range(hi_v, lo_v));
  endfunction

  // X: 1 left, 2 right. Y: 1 down, 2 up.
  function automatic logic [11:0] x_at(input int unsigned cls);
    return axis_sample(cls, x_right_thr, x_left_thr);
  endfunction

  function automatic logic [11:0] y_at(input int unsigned cls);
    return axis_sample(cls, y_up_thr, y_down_thr);
  endfunction

  function automatic logic [23:0] pick_steps();
    int unsigned cap, r;
    cap = (goal >= GOAL_MARGIN) ? goal - GOAL_MARGIN : 0;
    r = $urandom_range(0, 5);
    case (r)
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 600));
      3: return 24'($urandom_range(cap + 600, (cap > 600) ? cap - 600 : 0));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_goal();
    case ($urandom_range(0, 4))
      0: return 24'($urandom_range(0, 20));
      1: return 24'($urandom_range(0, 5000));
      2: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic btn_noise();
    return ($urandom_range(0, 7) == 0);
  endfunction

  // Flick right from rest until the goal progress page shows
  task automatic steer_to_goal_mode(input bit tight);
    int unsigned tries;
    tries = 0;
    while (!goal_setting && disp_mode != MODE_GOAL && tries < 4) begin
      send_word(make_word(x_at(0), y_at(0), 1'b0, 1'b0, pick_steps(), pick_goal()), tight);
      send_word(make_word(x_at(2), y_at(0), 1'b0, 1'b0, pick_steps(), pick_goal()), tight);
      tries++;
    end
  endtask

  task automatic test_axis_extremes();
    send_word(make_word(12'd0, 12'd0, 1'b0, 1'b0, 24'd0, 24'd0), 1'b0);
    send_word(make_word(12'hFFF, 12'hFFF, 1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF), 1'b0);
    send_word(make_word(12'(X_MIN), 12'(Y_MIN), 1'b0, 1'b0, 24'd77, 24'd0), 1'b0);
    send_word(make_word(12'(X_MAX), 12'(Y_MAX), 1'b0, 1'b1, 24'd500, 24'd0), 1'b0);
    send_word(make_word(12'(X_REST), 12'(Y_REST), 1'b0, 1'b1, 24'd123, 24'd0), 1'b0);
    send_word(make_word(12'd1, 12'd1, 1'b0, 1'b1, 24'd5, 24'd0), 1'b0);
    send_word(make_word(12'(X_REST + 1), 12'hFFF, 1'b0, 1'b1, 24'd3, 24'd0), 1'b0);
    send_word(make_word(12'(X_REST - 1), 12'd0, 1'b0, 1'b1, 24'hFFFFFF, 24'd0), 1'b0);
    // up edge on the distance page flips the distance unit
    send_word(make_word(12'hFFF, 12'(Y_REST), 1'b0, 1'b0, 24'd0, 24'd0), 1'b0);
    send_word(make_word(12'(X_REST), 12'd0, 1'b0, 1'b0, 24'd0, 24'd0), 1'b0);
  endtask

  task automatic test_goal_setting();
    write_settings(X_LEFT_RESET, X_RIGHT_RESET, Y_DOWN_RESET, Y_UP_RESET, 16'd2, GOAL_RESET);
    steer_to_goal_mode(1'b0);
    repeat (3) send_word(make_word(12'(X_REST), 12'(Y_REST), 1'b1, 1'b0, 24'd100, 24'd777),
                         1'b0);
    send_word(make_word(12'(X_REST), 12'(Y_REST), 1'b0, 1'b0, 24'd100, 24'd777), 1'b0);
    // confirm a goal below the margin, then nudge against a zero cap
    repeat (2) send_word(make_word(12'(X_REST), 12'(Y_REST), 1'b1, 1'b0, 24'd100, 24'd5),
                         1'b0);
    send_word(make_word(12'(X_REST), 12'(Y_REST), 1'b0, 1'b0, 24'd100, 24'd5), 1'b0);
    send_word(make_word(12'(X_REST), 12'd0, 1'b0, 1'b1, 24'd3, 24'd0), 1'b0);
    // enter, then cancel with a short press
    repeat (2) send_word(make_word(12'(X_REST), 12'(Y_REST), 1'b1, 1'b0, 24'd0, 24'd9), 1'b0);
    send_word(make_word(12'(X_REST), 12'hFFF, 1'b0, 1'b0, 24'd0, 24'd9), 1'b0);
    send_word(make_word(12'(X_REST), 12'hFFF, 1'b1, 1'b0, 24'd0, 24'd9), 1'b0);
    send_word(make_word(12'(X_REST), 12'(Y_REST), 1'b0, 1'b0, 24'd0, 24'd9), 1'b0);
  endtask

  task automatic test_overlap_and_zero_press();
    write_settings(X_LEFT_RESET, X_RIGHT_RESET, 12'd1000, 12'd3000, 16'd0, 24'd4242);
    steer_to_goal_mode(1'b0);
    // zero press length: each press word counts as long
    send_word(make_word(12'(X_REST), 12'd2000, 1'b1, 1'b0, 24'd0, 24'd0), 1'b0);
    send_word(make_word(12'(X_REST), 12'd2000, 1'b0, 1'b0, 24'd0, 24'd0), 1'b0);
    send_word(make_word(12'(X_REST), 12'd2000, 1'b1, 1'b0, 24'd0, 24'hFFFFFF), 1'b0);
    send_word(make_word(12'(X_REST), 12'd2000, 1'b0, 1'b0, 24'd0, 24'd0), 1'b0);
    // Y both above down and below up: floor first, then add
    send_word(make_word(12'(X_REST), 12'd2900, 1'b0, 1'b1, 24'd1, 24'd0), 1'b0);
    send_word(make_word(12'(X_REST), 12'd1001, 1'b0, 1'b1, 24'd7, 24'd0), 1'b0);
  endtask

  task automatic run_gesture_mix(input int unsigned n_words);
    int unsigned stop_at, kind, len, presses, lp;
    bit tight;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      kind  = $urandom_range(0, 9);
      tight = ($urandom_range(0, 3) == 0);
      lp    = long_press_thr;
      case (kind)
        0, 1: begin
          len = $urandom_range(1, 3);
          send_word(make_word(x_at(0), y_at(0), btn_noise(), 1'b0, pick_steps(), pick_goal()),
                    tight);
          repeat (len) send_word(make_word(x_at($urandom_range(1, 2)), y_at(0), btn_noise(),
                                           1'b0, pick_steps(), pick_goal()), tight);
          send_word(make_word(x_at(0), y_at(0), btn_noise(), 1'b0, pick_steps(), pick_goal()),
                    tight);
        end
        2: begin
          len = $urandom_range(1, 3);
          send_word(make_word(x_at(0), y_at(0), 1'b0, 1'b0, pick_steps(), pick_goal()), tight);
          repeat (len) send_word(make_word(x_at(0), y_at(2), btn_noise(), 1'b0, pick_steps(),
                                           pick_goal()), tight);
          send_word(make_word(x_at(0), y_at($urandom_range(0, 1)), 1'b0, 1'b0, pick_steps(),
                              pick_goal()), tight);
        end
        3, 4: begin
          steer_to_goal_mode(tight);
          presses = $urandom_range(1, 2);
          repeat (presses) begin
            if (lp > 50) len = $urandom_range(1, 50);
            else len = lp + $urandom_range(0, 3);
            len = (len > 1) ? len - 1 : 1;
            repeat (len) send_word(make_word(x_at(($urandom_range(0, 7) == 0) ? 3 : 0),
                                             y_at($urandom_range(0, 3)), 1'b1,
                                             ($urandom_range(0, 5) == 0), pick_steps(),
                                             pick_goal()), tight);
            repeat ($urandom_range(1, 3)) send_word(make_word(x_at(0), y_at(0), 1'b0,
                                                              ($urandom_range(0, 5) == 0),
                                                              pick_steps(), pick_goal()), tight);
          end
        end
        5, 6: begin
          len = $urandom_range(3, 10);
          repeat (len) send_word(make_word(x_at(($urandom_range(0, 4) == 0) ? 3 : 0),
                                           y_at($urandom_range(0, 3)), btn_noise(), 1'b1,
                                           pick_steps(), pick_goal()), tight);
        end
        7: begin
          len = $urandom_range(1, 5);
          repeat (len) send_word(make_word(12'($urandom), 12'($urandom), 1'($urandom),
                                           1'($urandom), 24'($urandom), 24'($urandom)), tight);
        end
        8: begin
          // broken press: too short where the press length is above one, stick moving meanwhile
          steer_to_goal_mode(tight);
          len = $urandom_range(1, (lp > 50) ? 50 : ((lp > 1) ? lp - 1 : 1));
          repeat (len) send_word(make_word(x_at($urandom_range(0, 3)), y_at($urandom_range(0, 3)),
                                           1'b1, 1'b0, pick_steps(), pick_goal()), tight);
          send_word(make_word(x_at(0), y_at(0), 1'b0, 1'b0, pick_steps(), pick_goal()), tight);
        end
        default: begin
          len = $urandom_range(1, 4);
          repeat (len) send_word(make_word(x_at(0), y_at(0), btn_noise(), 1'($urandom),
                                           pick_steps(), pick_goal()), tight);
        end
      endcase
    end
  endtask

  task automatic test_random_settings();
    int unsigned ph;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_settings(X_LEFT_RESET, X_RIGHT_RESET, Y_DOWN_RESET, Y_UP_RESET,
                          LONG_PRESS_RESET, GOAL_RESET);
        1: write_settings(12'hFFF, 12'h000, 12'hFFF, 12'h000, 16'hFFFF, 24'hFFFFFF);
        2: write_settings(12'h000, 12'hFFF, 12'h000, 12'hFFF, 16'd1, 24'd0);
        3: write_settings(12'($urandom_range(4000, 2300)), 12'($urandom_range(2100, 200)),
                          12'($urandom_range(2500, 0)), 12'($urandom_range(4095, 1500)),
                          16'($urandom_range(3, 0)), 24'($urandom));
        default: write_settings(12'($urandom_range(4000, 2300)), 12'($urandom_range(2100, 200)),
                                12'($urandom_range(4000, 2300)), 12'($urandom_range(2100, 200)),
                                16'($urandom_range(8, 1)), 24'($urandom));
      endcase
      run_gesture_mix(185);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_axis_extremes();
    test_goal_setting();
    test_overlap_and_zero_press();
    test_random_settings();
    wait_idle();
    repeat (10) @(negedge clk);
    $display("Covered %0d input words under %0d register settings; %0d results checked.",
             words_sent, settings_used + 1, results_checked);
    $display("Goal setting toggled %0d times; %0d words took the test-mode step nudge.",
             goal_toggles, nudged_words);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
